FILE: src/quantized_conv_mac_requant_core_defines.svh
// Assertion macros used by the checker of the MAC and requantization core.
`ifndef QUANTIZED_CONV_MAC_REQUANT_CORE_DEFINES_SVH
`define QUANTIZED_CONV_MAC_REQUANT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QCMR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qcmr check failed");

// Next-cycle implication.
`define QCMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qcmr check failed");

// Implication with a fixed delay in cycles.
`define QCMR_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("qcmr check failed");

`endif

FILE: src/qcmr_pkg.sv
// Shared types and constants of the quantized convolution MAC and requantization core.
package qcmr_pkg;

  // Lanes carried by one input beat and default number of lane instances.
  localparam int InLanes  = 2;
  localparam int DefLanes = 2;

  // Cycles from accepting a closing beat to its result being visible.
  localparam int RqLatency = 6;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegInputOffset  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOutputOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] RegActMin       = 2'd2;
  localparam logic [CfgIdxW-1:0] RegActMax       = 2'd3;

  typedef struct packed {
    logic signed [15:0] act_offset;
    logic signed [15:0] res_offset;
    logic signed [15:0] act_min;
    logic signed [15:0] act_max;
  } cfg_t;

  // Hand-over from the merging stage to the requantization pipeline.
  typedef struct packed {
    logic signed [31:0] acc;
    logic [30:0]        mult;
    logic signed [5:0]  shift;
  } rq_t;

endpackage

FILE: src/qcmr_lane.sv
// One MAC lane: offset activation times weight, gated by the lane enable.
module qcmr_lane (
  input  logic               en_i,
  input  logic signed [15:0] act_i,
  input  logic signed [7:0]  wgt_i,
  input  logic signed [15:0] in_off_i,
  output logic signed [31:0] prod_o
);
  import qcmr_pkg::*;

  logic signed [16:0] sum;
  logic signed [24:0] prod;

  assign sum    = 17'(act_i) + 17'(in_off_i);
  assign prod   = sum * 25'(wgt_i);
  assign prod_o = en_i ? 32'(prod) : '0;

endmodule

FILE: src/qcmr_merge.sv
// Merging stage: adds the lane products into the channel accumulator and hands off on the last beat.
module qcmr_merge #(
  parameter int NL = qcmr_pkg::InLanes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic                  last_i,
  input  logic [NL-1:0][31:0]   prod_i,
  input  logic signed [31:0]    bias_i,
  input  logic [30:0]           mult_i,
  input  logic signed [5:0]     shift_i,
  output logic                  rq_valid_o,
  output qcmr_pkg::rq_t         rq_o
);
  import qcmr_pkg::*;

  logic [31:0] acc_q, acc_d;
  logic [31:0] total;
  logic        rq_valid_q;
  rq_t         rq_q;

  always_comb begin
    total = acc_q;
    for (int i = 0; i < NL; i++) begin
      total = total + prod_i[i];
    end
    if (last_i) begin
      total = total + bias_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (take_i) begin
      acc_d = last_i ? '0 : total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      rq_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      rq_valid_q <= take_i & last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && last_i) begin
      rq_q.acc   <= total;
      rq_q.mult  <= mult_i;
      rq_q.shift <= shift_i;
    end
  end

  assign rq_valid_o = rq_valid_q;
  assign rq_o       = rq_q;

endmodule

FILE: src/qcmr_requant.sv
// Requantization pipeline: shift, doubling high multiply, rounding shift, offset, clamp.
module qcmr_requant (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rq_valid_i,
  input  qcmr_pkg::rq_t       rq_i,
  input  qcmr_pkg::cfg_t      cfg_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [15:0]  out_value_o,
  output logic                busy_o
);
  import qcmr_pkg::*;

  logic               v2_q, v3_q, v4_q, v5_q, out_valid_q, out_valid_d;
  logic signed [31:0] x2_q, x2_d;
  logic [30:0]        mult2_q;
  logic [4:0]         rs2_q, rs2_d, rs3_q, rs4_q;
  logic [5:0]         neg_sh;
  logic signed [63:0] prod3_q, prod3_d;
  logic signed [63:0] nudged;
  logic signed [31:0] dh4_q;
  logic signed [31:0] fl;
  logic [31:0]        mask, rem, thr;
  logic signed [31:0] r5_q, r5_d;
  logic signed [33:0] with_off;
  logic signed [15:0] out_q, out_d;

  // Left shift before the multiply, or the saturated right shift amount after it.
  always_comb begin
    neg_sh = 6'(6'd0 - $unsigned(rq_i.shift));
    if (rq_i.shift > 6'sd0) begin
      x2_d  = rq_i.acc << rq_i.shift[4:0];
      rs2_d = '0;
    end else begin
      x2_d  = rq_i.acc;
      rs2_d = neg_sh[5] ? 5'd31 : neg_sh[4:0];
    end
  end

  assign prod3_d = x2_q * $signed({1'b0, mult2_q});

  // The rounding nudge and truncation towards zero reduce to one floor shift.
  assign nudged = prod3_q + 64'sd1073741824;

  always_comb begin
    fl    = dh4_q >>> rs4_q;
    mask  = ~(32'hFFFF_FFFF << rs4_q);
    rem   = dh4_q & mask;
    thr   = {1'b0, mask[31:1]} + {31'd0, dh4_q[31]};
    r5_d  = fl + ((rem > thr) ? 32'sd1 : 32'sd0);
  end

  always_comb begin
    with_off = 34'(r5_q) + 34'(cfg_i.res_offset);
    if (with_off < 34'(cfg_i.act_min)) begin
      out_d = cfg_i.act_min;
    end else if (with_off > 34'(cfg_i.act_max)) begin
      out_d = cfg_i.act_max;
    end else begin
      out_d = with_off[15:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (v5_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v2_q        <= rq_valid_i;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q    <= x2_d;
    mult2_q <= rq_i.mult;
    rs2_q   <= rs2_d;
    prod3_q <= prod3_d;
    rs3_q   <= rs2_q;
    dh4_q   <= nudged[62:31];
    rs4_q   <= rs3_q;
    r5_q    <= r5_d;
    if (v5_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_q;
  assign busy_o      = rq_valid_i | v2_q | v3_q | v4_q | v5_q | out_valid_q;

endmodule

FILE: src/quantized_conv_mac_requant_core.sv
// Top level: quantized convolution multiply-accumulate with per-channel requantization.
// Beats that do not close a channel are taken one per cycle, back to back, with no wait.
// A closing beat reaches out_valid_o through the merging register and the
// requantization pipeline (shift, 32x32 multiply, rounding, offset and clamp).
// Only one channel is requantized at a time: a further closing beat waits until the result is taken.
// Reset clears the accumulator and the pipeline valid bits and loads the register defaults.
module quantized_conv_mac_requant_core #(
  parameter int LANES = qcmr_pkg::DefLanes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [qcmr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  // Input beats.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           activation_a_i,
  input  logic signed [15:0]           activation_b_i,
  input  logic signed [7:0]            weight_a_i,
  input  logic signed [7:0]            weight_b_i,
  input  logic [1:0]                   lane_count_i,
  input  logic                         last_tap_i,
  input  logic signed [31:0]           bias_i,
  input  logic [30:0]                  multiplier_i,
  input  logic signed [5:0]            shift_i,
  // Result beats.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           out_value_o
);
  import qcmr_pkg::*;

  // Lane instances actually fed: a beat carries at most InLanes taps.
  localparam int NL = (LANES < InLanes) ? LANES : InLanes;

  cfg_t                            cfg_q, cfg_d;
  logic [InLanes-1:0][15:0]        act_arr;
  logic [InLanes-1:0][7:0]         wgt_arr;
  logic [NL-1:0][31:0]             prod;
  logic                            take;
  logic                            rq_valid;
  rq_t                             rq;
  logic                            rq_busy;

  // Configuration registers; indexes outside the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInputOffset:  cfg_d.act_offset = cfg_wdata_i;
        RegOutputOffset: cfg_d.res_offset = cfg_wdata_i;
        RegActMin:       cfg_d.act_min    = cfg_wdata_i;
        RegActMax:       cfg_d.act_max    = cfg_wdata_i;
        default:         cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.act_offset <= 16'sd0;
      cfg_q.res_offset <= 16'sd0;
      cfg_q.act_min    <= 16'sh8000;
      cfg_q.act_max    <= 16'sh7fff;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A beat that keeps accumulating is always welcome; a closing beat needs the
  // requantization pipeline and the result register to be empty.
  assign in_ready_o = ~(last_tap_i & rq_busy);
  assign take       = in_valid_i & in_ready_o;

  assign act_arr[0] = activation_a_i;
  assign act_arr[1] = activation_b_i;
  assign wgt_arr[0] = weight_a_i;
  assign wgt_arr[1] = weight_b_i;

  // Lanes run side by side; lane i counts when the beat says more than i lanes are valid.
  for (genvar i = 0; i < NL; i++) begin : g_lane
    qcmr_lane u_lane (
      .en_i     (lane_count_i > 2'(i)),
      .act_i    ($signed(act_arr[i])),
      .wgt_i    ($signed(wgt_arr[i])),
      .in_off_i (cfg_q.act_offset),
      .prod_o   (prod[i])
    );
  end

  qcmr_merge #(
    .NL (NL)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .last_i     (last_tap_i),
    .prod_i     (prod),
    .bias_i     (bias_i),
    .mult_i     (multiplier_i),
    .shift_i    (shift_i),
    .rq_valid_o (rq_valid),
    .rq_o       (rq)
  );

  qcmr_requant u_requant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rq_valid_i  (rq_valid),
    .rq_i        (rq),
    .cfg_i       (cfg_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_value_o (out_value_o),
    .busy_o      (rq_busy)
  );

endmodule

FILE: src/qcmr_checker.sv
// Port-level checker of the MAC and requantization core, bound to the top level.
`include "quantized_conv_mac_requant_core_defines.svh"

module qcmr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               last_tap_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] out_value_o
);
  import qcmr_pkg::*;

  // A result waiting to be taken stays offered and unchanged.
  `QCMR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `QCMR_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_value_o))

  // Once a channel is closed, no second closing beat is taken until its result leaves.
  `QCMR_ASSERT_NEXT(a_one_channel, in_valid_i && in_ready_o && last_tap_i,
                    !last_tap_i || !in_ready_o)
  `QCMR_ASSERT_IMPL(a_result_blocks, out_valid_o, !(in_ready_o && last_tap_i))

  // A closing beat shows its result after the pipeline latency.
  `QCMR_ASSERT_DELAY(a_latency, in_valid_i && in_ready_o && last_tap_i, RqLatency,
                     out_valid_o)

endmodule

bind quantized_conv_mac_requant_core qcmr_checker u_qcmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_tap_i  (last_tap_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_value_o (out_value_o)
);

FILE: test/tb_top.sv
// Self-checking testbench of the quantized convolution MAC and requantization core.
`timescale 1ns / 100ps

module tb_top;
  import qcmr_pkg::*;

  // The run is stopped by force if it has not finished by this cycle count.
  localparam int CycleLimit = 400000;
  localparam logic [30:0] MultMax = 31'h7fffffff;
  localparam logic [30:0] MultHalf = 31'h40000000;

  // One input beat, laid out as the block sees it on its ports.
  typedef struct {
    logic signed [15:0] activation_a;
    logic signed [15:0] activation_b;
    logic signed [7:0]  weight_a;
    logic signed [7:0]  weight_b;
    logic [1:0]         lane_count;
    logic               last_tap;
    logic signed [31:0] bias;
    logic [30:0]        multiplier;
    logic signed [5:0]  shift;
  } tap_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [15:0]         cfg_wdata_i = '0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic signed [15:0]  activation_a_i;
  logic signed [15:0]  activation_b_i;
  logic signed [7:0]   weight_a_i;
  logic signed [7:0]   weight_b_i;
  logic [1:0]          lane_count_i;
  logic                last_tap_i;
  logic signed [31:0]  bias_i;
  logic [30:0]         multiplier_i;
  logic signed [5:0]   shift_i;

  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [15:0]  out_value_o;

  // The beat on the input port is held in one struct so that all of its fields
  // change together, at the clock edge, and stay put while valid is high.
  tap_beat_t drive_beat = '{default: '0};

  assign activation_a_i = drive_beat.activation_a;
  assign activation_b_i = drive_beat.activation_b;
  assign weight_a_i     = drive_beat.weight_a;
  assign weight_b_i     = drive_beat.weight_b;
  assign lane_count_i   = drive_beat.lane_count;
  assign last_tap_i     = drive_beat.last_tap;
  assign bias_i         = drive_beat.bias;
  assign multiplier_i   = drive_beat.multiplier;
  assign shift_i        = drive_beat.shift;

  // Beats waiting to be presented, and requantized values waiting to come out.
  tap_beat_t          pending_beats[$];
  logic signed [15:0] expected_outs[$];

  // Shadow copy of the configuration registers and of the channel accumulator.
  logic signed [15:0] act_offset  = 16'sh0000;
  logic signed [15:0] res_offset  = 16'sh0000;
  logic signed [15:0] act_min     = 16'sh8000;
  logic signed [15:0] act_max     = 16'sh7fff;
  logic [31:0]        channel_acc = '0;

  // While set, neither side inserts gaps, so the block runs at its full rate.
  bit no_idle = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  quantized_conv_mac_requant_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .activation_a_i (activation_a_i),
    .activation_b_i (activation_b_i),
    .weight_a_i     (weight_a_i),
    .weight_b_i     (weight_b_i),
    .lane_count_i   (lane_count_i),
    .last_tap_i     (last_tap_i),
    .bias_i         (bias_i),
    .multiplier_i   (multiplier_i),
    .shift_i        (shift_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Rounding doubling high multiply. The multiplier is never negative, so the
  // saturating corner only guards the general form of the operation.
  function automatic int dbl_high_mul(input int a, input int b);
    longint prod;
    longint nudge;
    if (a == 32'sh80000000 && b == 32'sh80000000) return 32'sh7fffffff;
    prod  = longint'(a) * longint'(b);
    nudge = (prod >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
    // Division of signed operands truncates towards zero, as required here.
    return int'((prod + nudge) / (longint'(1) << 31));
  endfunction

  // Rounding right shift by 0 to 31 places; ties are rounded away from zero.
  function automatic int round_shr(input int x, input int e);
    int unsigned mask;
    int unsigned rem;
    int unsigned thr;
    longint      floored;
    mask    = int'((longint'(1) << e) - 1);
    rem     = x & mask;
    thr     = (mask >> 1) + ((x < 0) ? 1 : 0);
    floored = longint'(x) >>> e;
    return int'(floored + ((rem > thr) ? 1 : 0));
  endfunction

  // Accumulates one accepted beat. On a closing beat it adds the bias,
  // requantizes, offsets and clamps, clears the accumulator and returns 1.
  function automatic bit predict_beat(input tap_beat_t b, output logic signed [15:0] value);
    int     lanes;
    int     sh;
    int     scaled;
    int     mult;
    longint res;
    logic [31:0] shifted;
    // A lane count of three is saturated to the two lanes present.
    lanes = (b.lane_count > 2) ? 2 : int'(b.lane_count);
    if (lanes >= 1)
      channel_acc += 32'((longint'(b.activation_a) + act_offset) * b.weight_a);
    if (lanes >= 2)
      channel_acc += 32'((longint'(b.activation_b) + act_offset) * b.weight_b);
    value = '0;
    if (!b.last_tap) return 1'b0;

    // The bias addition wraps, as does the accumulation.
    channel_acc += b.bias;
    sh   = b.shift;
    mult = int'({1'b0, b.multiplier});
    if (sh > 0) begin
      // Bits shifted out of the top are lost before the multiply.
      shifted = channel_acc << sh;
      scaled  = dbl_high_mul(signed'(shifted), mult);
    end else begin
      // A right shift by thirty-two is not available and is taken as 31.
      scaled = round_shr(dbl_high_mul(signed'(channel_acc), mult), (-sh > 31) ? 31 : -sh);
    end
    // The output offset is added at full width, so it cannot wrap. With the
    // bounds crossed, the lower bound is tested first.
    res = longint'(scaled) + res_offset;
    if (res < act_min) res = act_min;
    else if (res > act_max) res = act_max;
    value = res[15:0];
    channel_acc = '0;
    return 1'b1;
  endfunction

  // Input driver. The expectation is formed at the edge where a beat is
  // accepted, from the beat that was on the port during the cycle before.
  always @(posedge clk_i or negedge rst_ni) begin : input_driver
    logic signed [15:0] value;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (predict_beat(drive_beat, value)) expected_outs.push_back(value);
      end
      // A new beat may only go out once the one on the port has been taken.
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= 38)) begin
          drive_beat <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each result beat is matched against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    logic signed [15:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outs.size() == 0) begin
          $error("out_value: unexpected result beat, expected none, actual %0d", out_value_o);
          fail_count++;
        end else begin
          want = expected_outs.pop_front();
          if (out_value_o !== want) begin
            $error("out_value mismatch: expected %0d, actual %0d", want, out_value_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The shadow register is updated at once; the block is idle while this runs.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic signed [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegInputOffset:  act_offset = val;
      RegOutputOffset: res_offset = val;
      RegActMin:       act_min    = val;
      RegActMax:       act_max    = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [15:0] in_off, input logic signed [15:0] out_off,
                            input logic signed [15:0] lo, input logic signed [15:0] hi);
    write_reg(RegInputOffset, in_off);
    write_reg(RegOutputOffset, out_off);
    write_reg(RegActMin, lo);
    write_reg(RegActMax, hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every beat has been taken and every result has come out, then
  // lets the requantization pipeline run dry before anything else is done.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid_i || expected_outs.size() != 0)
      @(posedge clk_i);
    repeat (RqLatency + 4) @(posedge clk_i);
  endtask

  function automatic tap_beat_t mk_beat(input int act_a, input int act_b, input int wgt_a,
                                        input int wgt_b, input int lanes, input bit last,
                                        input int bias, input logic [30:0] mult, input int sh);
    tap_beat_t b;
    b.activation_a = 16'(act_a);
    b.activation_b = 16'(act_b);
    b.weight_a     = 8'(wgt_a);
    b.weight_b     = 8'(wgt_b);
    b.lane_count   = 2'(lanes);
    b.last_tap     = last;
    b.bias         = bias;
    b.multiplier   = mult;
    b.shift        = 6'(sh);
    return b;
  endfunction

  // Random beat. The multiplier and shift lean towards values that keep the
  // result inside the int16 range, so that the rounding is actually seen.
  function automatic tap_beat_t rand_beat(input bit last);
    tap_beat_t b;
    int r;
    b.activation_a = 16'($urandom);
    b.activation_b = 16'($urandom);
    b.weight_a     = 8'($urandom);
    b.weight_b     = 8'($urandom);
    r = $urandom_range(99);
    b.lane_count = (r < 8) ? 2'd0 : (r < 16) ? 2'd3 : (r < 40) ? 2'd1 : 2'd2;
    b.last_tap = last;
    r = $urandom_range(99);
    b.bias = (r < 70) ? 32'($urandom_range(2000000) - 1000000) : 32'($urandom);
    r = $urandom_range(99);
    if (r < 60)      b.multiplier = 31'($urandom_range(32'h7fffffff, 32'h40000000));
    else if (r < 80) b.multiplier = 31'($urandom);
    else if (r < 85) b.multiplier = '0;
    else if (r < 90) b.multiplier = MultMax;
    else             b.multiplier = 31'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 70)      b.shift = 6'(-int'($urandom_range(20, 6)));
    else if (r < 85) b.shift = 6'($urandom_range(63));
    else             b.shift = 6'(int'($urandom_range(10)) - 5);
    return b;
  endfunction

  // Channels of random depth, each closed by a beat with last_tap set.
  task automatic queue_random(input int n_items);
    int added;
    int taps;
    int r;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(99);
      taps = (r < 8) ? $urandom_range(40, 10) : $urandom_range(8, 1);
      for (int k = 0; k < taps; k++) pending_beats.push_back(rand_beat(k == taps - 1));
      added += taps;
    end
  endtask

  // A long channel of identical extreme taps, deep enough that the
  // accumulator wraps once the input offset is at one of its extremes.
  task automatic queue_wrap_channel(input int act, input int wgt);
    for (int k = 0; k < 140; k++)
      pending_beats.push_back(mk_beat(act, act, wgt, wgt, 2, k == 139, 0, MultMax, -16));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed beats with the reset values of the registers.
    pending_beats.push_back(mk_beat(32767, 32767, 127, 127, 2, 0, 0, 0, 0));
    // Extreme taps on both lanes; the result saturates at the upper bound.
    pending_beats.push_back(mk_beat(-32768, -32768, -128, -128, 2, 1, 0, MultMax, 0));
    // No lane contributes, but the channel still closes on the bias alone.
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 1, 12345, MultHalf, -1));
    // Lane count above two, largest bias and the right shift by thirty-two.
    pending_beats.push_back(mk_beat(-32768, 32767, 127, -128, 3, 1, 32'h7fffffff, MultMax, -32));
    // Smallest bias and the largest left shift, which wraps the accumulator.
    pending_beats.push_back(mk_beat(1000, -1000, 100, -100, 1, 1, 32'h80000000, MultMax, 31));
    // A zero multiplier.
    pending_beats.push_back(mk_beat(12345, -4321, 77, -55, 2, 1, 0, 0, -3));
    pending_beats.push_back(mk_beat(300, -200, 3, 4, 2, 1, -50, MultHalf, 5));
    pending_beats.push_back(mk_beat(-1, -1, -1, -1, 2, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(5, 5, 5, 5, 1, 1, 0, MultMax, -31));
    // The largest bias is added to a negative sum of extreme taps.
    pending_beats.push_back(mk_beat(32767, -32768, -128, 127, 2, 1, 32'h7fffffff, MultMax, 0));
    // Halfway cases of the rounding, on both signs.
    pending_beats.push_back(mk_beat(-7, 0, 1, 0, 1, 1, 0, MultHalf, -1));
    pending_beats.push_back(mk_beat(7, 0, 1, 0, 1, 1, 0, MultHalf, -1));
    pending_beats.push_back(mk_beat(-3, 0, 1, 0, 1, 1, 0, MultMax, -1));
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 0, 99, MultMax, 7));
    pending_beats.push_back(mk_beat(3, 0, 1, 0, 1, 1, 0, MultMax, 0));
    // The result saturates at the lower bound.
    pending_beats.push_back(mk_beat(-20000, 0, 127, 0, 1, 1, 0, MultMax, 0));
    pending_beats.push_back(mk_beat(12, 34, 56, 78, 2, 1, 0, MultHalf, 2));
    queue_random(150);
    wait_idle();

    for (int phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: set_config(16'($urandom), 16'(int'($urandom_range(400)) - 200), -16'sd1000, 16'sd1000);
        2: set_config(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        3: set_config(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        // Crossed bounds: every value ends up on one of them.
        4: set_config(16'($urandom), 16'($urandom), 16'sd50, -16'sd50);
        5: begin
          act_min = 16'($urandom);
          set_config(16'($urandom), 16'($urandom), act_min, act_min);
        end
        default: set_config(16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff);
      endcase
      // One phase runs with no gaps on either side.
      no_idle = (phase == 3);
      if (phase == 2) queue_wrap_channel(-32768, -128);
      if (phase == 3) queue_wrap_channel(32767, 127);
      queue_random(200);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
